@@ src/lsrc_pkg.sv @@
// package for the line segment rectangle clipper: defaults, reset values, register indexes
`default_nettype none

package lsrc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_IDX_BITS   = 2;

  localparam int WIN_MIN_RESET  = 0;
  localparam int WIN_MAX_RESET  = 4095;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_X_MIN = 2'd0,
    CFG_Y_MIN = 2'd1,
    CFG_X_MAX = 2'd2,
    CFG_Y_MAX = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ src/line_segment_rect_clipper.sv @@
// line segment clipper against an axis-aligned rectangle, parametric method, fully pipelined
//
// usage:
//   in_*   : one segment per transaction (start and end point, signed), valid/ready
//   out_*  : clipped endpoints plus a rejected flag, one transaction per segment, valid/ready
//   cfg_*  : write-only window registers (x_min, y_min, x_max, y_max), written while idle
// throughput: one segment per cycle unless stalled; pipeline length is set by the bit-serial
//   quotient stages (one quotient bit per stage, COORD_BITS stages, four lanes side by side)
// stages: deltas and edge distances, clamp to [0,1], cross products of candidates, pick
//   entry/exit parameters, products for reject test and endpoint scaling, reject compare and
//   divider load, COORD_BITS divider steps, truncation fixup into the output register
// reset: window returns to 0..4095 on both axes, all valid bits clear, out_valid low
// stall: when out_valid is high and out_ready low the whole pipeline holds, in_ready drops,
//   nothing is lost or repeated; bubbles are not squeezed out while the output waits
// rejected segments come out with all-zero coordinates and rejected set
`default_nettype none

module line_segment_rect_clipper #(
  parameter int COORD_BITS = lsrc_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_write_en,
  input  wire logic [lsrc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [COORD_BITS-1:0]               cfg_data,
  // input segment
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [COORD_BITS-1:0]        in_start_x,
  input  wire logic signed [COORD_BITS-1:0]        in_start_y,
  input  wire logic signed [COORD_BITS-1:0]        in_end_x,
  input  wire logic signed [COORD_BITS-1:0]        in_end_y,
  // clipped segment
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [COORD_BITS-1:0]             out_clip_start_x,
  output logic signed [COORD_BITS-1:0]             out_clip_start_y,
  output logic signed [COORD_BITS-1:0]             out_clip_end_x,
  output logic signed [COORD_BITS-1:0]             out_clip_end_y,
  output logic                                     out_rejected
);

  localparam int CW = COORD_BITS;
  localparam int NW = CW + 2;          // signed numerator width
  localparam int PW = NW + CW + 1;     // signed cross product width

  // window registers
  logic signed [CW-1:0] win_x_min_r, win_y_min_r, win_x_max_r, win_y_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_x_min_r <= CW'(lsrc_pkg::WIN_MIN_RESET);
      win_y_min_r <= CW'(lsrc_pkg::WIN_MIN_RESET);
      win_x_max_r <= CW'(lsrc_pkg::WIN_MAX_RESET);
      win_y_max_r <= CW'(lsrc_pkg::WIN_MAX_RESET);
    end else if (cfg_write_en) begin
      case (lsrc_pkg::cfg_idx_t'(cfg_index))
        lsrc_pkg::CFG_X_MIN: win_x_min_r <= cfg_data;
        lsrc_pkg::CFG_Y_MIN: win_y_min_r <= cfg_data;
        lsrc_pkg::CFG_X_MAX: win_x_max_r <= cfg_data;
        lsrc_pkg::CFG_Y_MAX: win_y_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: pipeline moves unless the output holds a transaction not taken
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: deltas and edge distances ----------------
  logic signed [CW:0]   dx_c, dy_c;
  logic signed [CW:0]   qxa_c, qxb_c, qya_c, qyb_c;   // min - s, max - s
  logic signed [NW-1:0] ent_x_c, ext_x_c, ent_y_c, ext_y_c;
  logic [CW-1:0]        adx_c, ady_c;
  logic                 rjp_c;

  always_comb begin
    dx_c  = {in_end_x[CW-1], in_end_x} - {in_start_x[CW-1], in_start_x};
    dy_c  = {in_end_y[CW-1], in_end_y} - {in_start_y[CW-1], in_start_y};
    qxa_c = {win_x_min_r[CW-1], win_x_min_r} - {in_start_x[CW-1], in_start_x};
    qxb_c = {win_x_max_r[CW-1], win_x_max_r} - {in_start_x[CW-1], in_start_x};
    qya_c = {win_y_min_r[CW-1], win_y_min_r} - {in_start_y[CW-1], in_start_y};
    qyb_c = {win_y_max_r[CW-1], win_y_max_r} - {in_start_y[CW-1], in_start_y};
    adx_c = dx_c[CW] ? CW'(-dx_c) : dx_c[CW-1:0];
    ady_c = dy_c[CW] ? CW'(-dy_c) : dy_c[CW-1:0];
    // positive delta: entry at min edge, exit at max edge; negative delta swaps them
    if (dx_c[CW]) begin
      ent_x_c = -NW'(qxb_c);
      ext_x_c = -NW'(qxa_c);
    end else begin
      ent_x_c = NW'(qxa_c);
      ext_x_c = NW'(qxb_c);
    end
    if (dy_c[CW]) begin
      ent_y_c = -NW'(qyb_c);
      ext_y_c = -NW'(qya_c);
    end else begin
      ent_y_c = NW'(qya_c);
      ext_y_c = NW'(qyb_c);
    end
    // parallel to an axis and outside its slab
    rjp_c = ((dx_c == '0) && (qxa_c > 0 || qxb_c < 0)) ||
            ((dy_c == '0) && (qya_c > 0 || qyb_c < 0));
  end

  logic                 v1_r;
  logic signed [CW-1:0] s1_x_r, s1_y_r;
  logic                 s1_xz_r, s1_yz_r, s1_xn_r, s1_yn_r, s1_rjp_r;
  logic [CW-1:0]        s1_adx_r, s1_ady_r;
  logic signed [NW-1:0] s1_ent_x_r, s1_ext_x_r, s1_ent_y_r, s1_ext_y_r;

  // ---------------- stage 2: clamp candidates to [0,1] ----------------
  logic signed [NW-1:0] ent_x2_c, ext_x2_c, ent_y2_c, ext_y2_c;
  logic [CW-1:0]        den_x2_c, den_y2_c;

  always_comb begin
    if (s1_xz_r) begin
      ent_x2_c = '0;
      ext_x2_c = NW'(1);
      den_x2_c = CW'(1);
    end else begin
      ent_x2_c = (s1_ent_x_r < 0) ? '0 : s1_ent_x_r;
      ext_x2_c = (s1_ext_x_r > $signed({2'b00, s1_adx_r})) ?
                 $signed({2'b00, s1_adx_r}) : s1_ext_x_r;
      den_x2_c = s1_adx_r;
    end
    if (s1_yz_r) begin
      ent_y2_c = '0;
      ext_y2_c = NW'(1);
      den_y2_c = CW'(1);
    end else begin
      ent_y2_c = (s1_ent_y_r < 0) ? '0 : s1_ent_y_r;
      ext_y2_c = (s1_ext_y_r > $signed({2'b00, s1_ady_r})) ?
                 $signed({2'b00, s1_ady_r}) : s1_ext_y_r;
      den_y2_c = s1_ady_r;
    end
  end

  logic                 v2_r;
  logic signed [CW-1:0] s2_x_r, s2_y_r;
  logic                 s2_xn_r, s2_yn_r, s2_rjp_r;
  logic [CW-1:0]        s2_adx_r, s2_ady_r, s2_den_x_r, s2_den_y_r;
  logic signed [NW-1:0] s2_ent_x_r, s2_ext_x_r, s2_ent_y_r, s2_ext_y_r;

  // ---------------- stage 3: cross products of candidates ----------------
  logic signed [PW-1:0] pe_xy_c, pe_yx_c, px_xy_c, px_yx_c;
  assign pe_xy_c = s2_ent_x_r * $signed({1'b0, s2_den_y_r});
  assign pe_yx_c = s2_ent_y_r * $signed({1'b0, s2_den_x_r});
  assign px_xy_c = s2_ext_x_r * $signed({1'b0, s2_den_y_r});
  assign px_yx_c = s2_ext_y_r * $signed({1'b0, s2_den_x_r});

  logic                 v3_r;
  logic signed [CW-1:0] s3_x_r, s3_y_r;
  logic                 s3_xn_r, s3_yn_r, s3_rjp_r;
  logic [CW-1:0]        s3_adx_r, s3_ady_r, s3_den_x_r, s3_den_y_r;
  logic signed [NW-1:0] s3_ent_x_r, s3_ext_x_r, s3_ent_y_r, s3_ext_y_r;
  logic signed [PW-1:0] s3_pe_xy_r, s3_pe_yx_r, s3_px_xy_r, s3_px_yx_r;

  // ---------------- stage 4: entry is the larger, exit the smaller ----------------
  logic signed [NW-1:0] n1_c, n2_c;
  logic [CW-1:0]        d1_c, d2_c;

  always_comb begin
    if (s3_pe_xy_r >= s3_pe_yx_r) begin
      n1_c = s3_ent_x_r;
      d1_c = s3_den_x_r;
    end else begin
      n1_c = s3_ent_y_r;
      d1_c = s3_den_y_r;
    end
    if (s3_px_xy_r <= s3_px_yx_r) begin
      n2_c = s3_ext_x_r;
      d2_c = s3_den_x_r;
    end else begin
      n2_c = s3_ext_y_r;
      d2_c = s3_den_y_r;
    end
  end

  logic                 v4_r;
  logic signed [CW-1:0] s4_x_r, s4_y_r;
  logic                 s4_xn_r, s4_yn_r, s4_rjp_r;
  logic [CW-1:0]        s4_adx_r, s4_ady_r, s4_d1_r, s4_d2_r;
  logic signed [NW-1:0] s4_n1_r, s4_n2_r;

  // ---------------- stage 5: reject products and endpoint scaling products ----------------
  logic signed [PW-1:0] rc_a_c, rc_b_c;
  logic [2*CW-1:0]      pr_c [0:3];   // start x, start y, end x, end y

  assign rc_a_c = s4_n1_r * $signed({1'b0, s4_d2_r});
  assign rc_b_c = s4_n2_r * $signed({1'b0, s4_d1_r});
  assign pr_c[0] = s4_n1_r[CW-1:0] * s4_adx_r;
  assign pr_c[1] = s4_n1_r[CW-1:0] * s4_ady_r;
  assign pr_c[2] = s4_n2_r[CW-1:0] * s4_adx_r;
  assign pr_c[3] = s4_n2_r[CW-1:0] * s4_ady_r;

  logic                 v5_r;
  logic signed [CW-1:0] s5_x_r, s5_y_r;
  logic                 s5_xn_r, s5_yn_r, s5_rjp_r;
  logic [CW-1:0]        s5_d1_r, s5_d2_r;
  logic signed [PW-1:0] s5_rc_a_r, s5_rc_b_r;
  logic [2*CW-1:0]      s5_pr_r [0:3];

  // ---------------- stage 6 onward: bit-serial dividers, four lanes ----------------
  // lane j: bit 0 picks the axis, bit 1 picks entry or exit parameter
  logic                 dv_v_r   [0:CW];
  logic                 dv_rej_r [0:CW];
  logic signed [CW-1:0] dv_s_r   [0:CW][0:1];
  logic                 dv_neg_r [0:CW][0:1];
  logic [CW-1:0]        dv_div_r [0:CW][0:1];
  logic [CW-1:0]        dv_rem_r [0:CW][0:3];
  logic [CW-1:0]        dv_low_r [0:CW][0:3];
  logic [CW-1:0]        dv_quo_r [0:CW][0:3];

  logic [CW-1:0]        dv_rem_nxt [1:CW][0:3];
  logic [CW-1:0]        dv_quo_nxt [1:CW][0:3];

  always_comb begin
    logic [CW:0] t_v;
    logic [CW:0] d_v;
    for (int k = 1; k <= CW; k++) begin
      for (int j = 0; j < 4; j++) begin
        t_v = {dv_rem_r[k-1][j], dv_low_r[k-1][j][CW-1]};
        d_v = {1'b0, dv_div_r[k-1][j/2]};
        if (t_v >= d_v) begin
          dv_rem_nxt[k][j] = CW'(t_v - d_v);
          dv_quo_nxt[k][j] = {dv_quo_r[k-1][j][CW-2:0], 1'b1};
        end else begin
          dv_rem_nxt[k][j] = t_v[CW-1:0];
          dv_quo_nxt[k][j] = {dv_quo_r[k-1][j][CW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- final: truncation toward zero ----------------
  logic signed [CW-1:0] res_c [0:3];

  always_comb begin
    logic              rnz_v;
    logic signed [NW-1:0] f_v;
    logic signed [NW-1:0] b_v;
    for (int j = 0; j < 4; j++) begin
      rnz_v = |dv_rem_r[CW][j];
      if (dv_neg_r[CW][j%2])
        f_v = -($signed({2'b00, dv_quo_r[CW][j]}) + $signed(NW'(rnz_v)));
      else
        f_v = $signed({2'b00, dv_quo_r[CW][j]});
      b_v = NW'(dv_s_r[CW][j%2]) + f_v;
      if (rnz_v && b_v < 0)
        b_v = b_v + NW'(1);
      res_c[j] = dv_rej_r[CW] ? '0 : b_v[CW-1:0];
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      for (int k = 0; k <= CW; k++) dv_v_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      dv_v_r[0]   <= v5_r;
      for (int k = 1; k <= CW; k++) dv_v_r[k] <= dv_v_r[k-1];
      out_valid_r <= dv_v_r[CW];
    end
  end

  // ---------------- payload ----------------
  logic signed [CW-1:0] out_sx_r, out_sy_r, out_ex_r, out_ey_r;
  logic                 out_rej_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      s1_x_r     <= in_start_x;
      s1_y_r     <= in_start_y;
      s1_xz_r    <= (dx_c == '0);
      s1_yz_r    <= (dy_c == '0);
      s1_xn_r    <= dx_c[CW];
      s1_yn_r    <= dy_c[CW];
      s1_rjp_r   <= rjp_c;
      s1_adx_r   <= adx_c;
      s1_ady_r   <= ady_c;
      s1_ent_x_r <= ent_x_c;
      s1_ext_x_r <= ext_x_c;
      s1_ent_y_r <= ent_y_c;
      s1_ext_y_r <= ext_y_c;
      // stage 2
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
      s2_xn_r    <= s1_xn_r;
      s2_yn_r    <= s1_yn_r;
      s2_rjp_r   <= s1_rjp_r;
      s2_adx_r   <= s1_adx_r;
      s2_ady_r   <= s1_ady_r;
      s2_den_x_r <= den_x2_c;
      s2_den_y_r <= den_y2_c;
      s2_ent_x_r <= ent_x2_c;
      s2_ext_x_r <= ext_x2_c;
      s2_ent_y_r <= ent_y2_c;
      s2_ext_y_r <= ext_y2_c;
      // stage 3
      s3_x_r     <= s2_x_r;
      s3_y_r     <= s2_y_r;
      s3_xn_r    <= s2_xn_r;
      s3_yn_r    <= s2_yn_r;
      s3_rjp_r   <= s2_rjp_r;
      s3_adx_r   <= s2_adx_r;
      s3_ady_r   <= s2_ady_r;
      s3_den_x_r <= s2_den_x_r;
      s3_den_y_r <= s2_den_y_r;
      s3_ent_x_r <= s2_ent_x_r;
      s3_ext_x_r <= s2_ext_x_r;
      s3_ent_y_r <= s2_ent_y_r;
      s3_ext_y_r <= s2_ext_y_r;
      s3_pe_xy_r <= pe_xy_c;
      s3_pe_yx_r <= pe_yx_c;
      s3_px_xy_r <= px_xy_c;
      s3_px_yx_r <= px_yx_c;
      // stage 4
      s4_x_r     <= s3_x_r;
      s4_y_r     <= s3_y_r;
      s4_xn_r    <= s3_xn_r;
      s4_yn_r    <= s3_yn_r;
      s4_rjp_r   <= s3_rjp_r;
      s4_adx_r   <= s3_adx_r;
      s4_ady_r   <= s3_ady_r;
      s4_n1_r    <= n1_c;
      s4_d1_r    <= d1_c;
      s4_n2_r    <= n2_c;
      s4_d2_r    <= d2_c;
      // stage 5
      s5_x_r     <= s4_x_r;
      s5_y_r     <= s4_y_r;
      s5_xn_r    <= s4_xn_r;
      s5_yn_r    <= s4_yn_r;
      s5_rjp_r   <= s4_rjp_r;
      s5_d1_r    <= s4_d1_r;
      s5_d2_r    <= s4_d2_r;
      s5_rc_a_r  <= rc_a_c;
      s5_rc_b_r  <= rc_b_c;
      for (int j = 0; j < 4; j++) s5_pr_r[j] <= pr_c[j];
      // divider load: entry after exit rejects
      dv_rej_r[0]    <= s5_rjp_r || (s5_rc_a_r > s5_rc_b_r);
      dv_s_r[0][0]   <= s5_x_r;
      dv_s_r[0][1]   <= s5_y_r;
      dv_neg_r[0][0] <= s5_xn_r;
      dv_neg_r[0][1] <= s5_yn_r;
      dv_div_r[0][0] <= s5_d1_r;
      dv_div_r[0][1] <= s5_d2_r;
      for (int j = 0; j < 4; j++) begin
        dv_rem_r[0][j] <= s5_pr_r[j][2*CW-1:CW];
        dv_low_r[0][j] <= s5_pr_r[j][CW-1:0];
        dv_quo_r[0][j] <= '0;
      end
      // divider steps
      for (int k = 1; k <= CW; k++) begin
        dv_rej_r[k] <= dv_rej_r[k-1];
        for (int a = 0; a < 2; a++) begin
          dv_s_r[k][a]   <= dv_s_r[k-1][a];
          dv_neg_r[k][a] <= dv_neg_r[k-1][a];
          dv_div_r[k][a] <= dv_div_r[k-1][a];
        end
        for (int j = 0; j < 4; j++) begin
          dv_rem_r[k][j] <= dv_rem_nxt[k][j];
          dv_low_r[k][j] <= {dv_low_r[k-1][j][CW-2:0], 1'b0};
          dv_quo_r[k][j] <= dv_quo_nxt[k][j];
        end
      end
      // output register
      out_sx_r  <= res_c[0];
      out_sy_r  <= res_c[1];
      out_ex_r  <= res_c[2];
      out_ey_r  <= res_c[3];
      out_rej_r <= dv_rej_r[CW];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_clip_start_x = out_sx_r;
  assign out_clip_start_y = out_sy_r;
  assign out_clip_end_x   = out_ex_r;
  assign out_clip_end_y   = out_ey_r;
  assign out_rejected     = out_rej_r;

endmodule

`default_nettype wire
